FILE: rtl/ssk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssk_pkg
// shared types and constants of the stock span stack
// ----------------------------------------------------------------------------
package ssk_pkg;

  localparam int PRICE_W         = 32;
  localparam int OUT_SPAN_W      = 16;
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_SPAN_BITS   = 16;
  localparam int IQ_DEPTH        = 2;
  localparam int IQ_PTR_W        = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W        = $clog2(IQ_DEPTH + 1);

  typedef struct packed {
    logic signed [PRICE_W-1:0] price;
    logic                      start_of_series;
  } item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } eng_state_t;

endpackage
`default_nettype wire

FILE: rtl/stock_span_stack_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stock_span_stack_top
// streaming stock span unit on a monotonic stack
// ----------------------------------------------------------------------------
// input side is a queue: an item (price, start_of_series) is taken when
// in_push is high and in_full is low; a two-entry queue holds items ahead
// of the stack engine.
// result side is a queue: out_span_days and out_history_lost are valid while
// out_empty is low and are taken when out_pop is high.
// one result per item, in order. the engine takes an item in its idle state;
// in its scan state it pops entries while the top is no greater than the
// price, at the pace set by the registered read of the stack memory, then
// pushes the item and writes its result once the result register is free.
// the stack sits in a circular memory, so dropping the bottom entry when it
// is full costs nothing extra.
// reset empties the queue, the stack and the result register; no clearing
// pass is needed. if the receiver stalls, the result holds and the engine
// keeps popping for its item until its next result is due, then waits.
// ----------------------------------------------------------------------------
module stock_span_stack_top #(
  parameter int STACK_DEPTH = ssk_pkg::DEF_STACK_DEPTH,
  parameter int SPAN_BITS   = ssk_pkg::DEF_SPAN_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic signed [ssk_pkg::PRICE_W-1:0] in_price,
  input  wire logic                              in_start_of_series,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic [ssk_pkg::OUT_SPAN_W-1:0]         out_span_days,
  output logic                                   out_history_lost
);

  ssk_pkg::item_t in_item, q_item;
  logic           q_avail, q_pop;

  assign in_item.price           = in_price;
  assign in_item.start_of_series = in_start_of_series;

  ssk_in_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (in_item),
    .full      (in_full),
    .avail     (q_avail),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  ssk_engine #(
    .STACK_DEPTH (STACK_DEPTH),
    .SPAN_BITS   (SPAN_BITS)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_avail          (q_avail),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_span_days    (out_span_days),
    .out_history_lost (out_history_lost)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (SPAN_BITS > ssk_pkg::OUT_SPAN_W) || out_empty || (out_span_days != '0))
    else $error("zero span on result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_span_days) && $stable(out_history_lost)))
    else $error("waiting result overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/ssk_in_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssk_in_queue
// front part: takes input items and holds them for the stack engine
// ----------------------------------------------------------------------------
module ssk_in_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ssk_pkg::item_t push_item,
  output logic                full,
  output logic                avail,
  input  wire logic           pop,
  output ssk_pkg::item_t      pop_item
);

  ssk_pkg::item_t                  mem_r [ssk_pkg::IQ_DEPTH];
  logic [ssk_pkg::IQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ssk_pkg::IQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ssk_pkg::IQ_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                            do_wr, do_rd;

  localparam logic [ssk_pkg::IQ_PTR_W-1:0] PTR_LAST = ssk_pkg::IQ_PTR_W'(ssk_pkg::IQ_DEPTH - 1);
  localparam logic [ssk_pkg::IQ_CNT_W-1:0] CNT_FULL = ssk_pkg::IQ_CNT_W'(ssk_pkg::IQ_DEPTH);

  assign full     = (cnt_r == CNT_FULL);
  assign avail    = (cnt_r != '0);
  assign do_wr    = push && !full;
  assign do_rd    = pop && avail;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ssk_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssk_engine
// back part: monotonic stack in a circular memory and the result register
// ----------------------------------------------------------------------------
module ssk_engine #(
  parameter int STACK_DEPTH = ssk_pkg::DEF_STACK_DEPTH,
  parameter int SPAN_BITS   = ssk_pkg::DEF_SPAN_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_avail,
  input  wire ssk_pkg::item_t                  q_item,
  output logic                                 q_pop,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [ssk_pkg::OUT_SPAN_W-1:0]       out_span_days,
  output logic                                 out_history_lost
);

  localparam int PTR_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ENTRY_W = ssk_pkg::PRICE_W + SPAN_BITS;
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(STACK_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STACK_DEPTH - 1);

  ssk_pkg::eng_state_t state_r, state_nxt;

  logic [ENTRY_W-1:0]                mem [STACK_DEPTH];
  logic [ENTRY_W-1:0]                rd_data_r;
  logic [PTR_W-1:0]                  base_r, base_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              lost_r, lost_nxt;
  logic signed [ssk_pkg::PRICE_W-1:0] price_r, price_nxt;
  logic [SPAN_BITS-1:0]              days_r, days_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [ssk_pkg::OUT_SPAN_W-1:0]    out_span_r, out_span_nxt;
  logic                              out_lost_r, out_lost_nxt;

  logic signed [ssk_pkg::PRICE_W-1:0] top_val;
  logic [SPAN_BITS-1:0]              top_span;
  logic                              pop_hit, out_free, do_push, do_take;
  logic [SPAN_BITS:0]                span_sum;
  logic [SPAN_BITS-1:0]              span_sat;
  logic [PTR_W-1:0]                  rd_idx, wr_idx;
  logic [31:0]                       days_ext;

  function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[PTR_W-1:0];
  endfunction

  assign top_val  = rd_data_r[ENTRY_W-1:SPAN_BITS];
  assign top_span = rd_data_r[SPAN_BITS-1:0];
  assign pop_hit  = (cnt_r != '0) && (top_val <= price_r);
  assign out_free = !out_valid_r || out_pop;
  assign span_sum = {1'b0, days_r} + {1'b0, top_span};
  assign span_sat = span_sum[SPAN_BITS] ? '1 : span_sum[SPAN_BITS-1:0];
  assign wr_idx   = wrap_idx(SUM_W'(base_r) + SUM_W'(cnt_r));
  assign rd_idx   = (cnt_nxt == '0) ? base_nxt
                                    : wrap_idx(SUM_W'(base_nxt) + SUM_W'(cnt_nxt) - 1'b1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssk_pkg::ST_IDLE: begin
        if (q_avail) begin
          state_nxt = ssk_pkg::ST_SCAN;
        end
      end
      ssk_pkg::ST_SCAN: begin
        if (!pop_hit && out_free) begin
          state_nxt = ssk_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssk_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    do_take = 1'b0;
    do_push = 1'b0;
    unique case (state_r)
      ssk_pkg::ST_IDLE: do_take = q_avail;
      ssk_pkg::ST_SCAN: do_push = !pop_hit && out_free;
      default: ;
    endcase
  end

  assign q_pop = do_take;

  always_comb begin
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    lost_nxt      = lost_r;
    price_nxt     = price_r;
    days_nxt      = days_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_span_nxt  = out_span_r;
    out_lost_nxt  = out_lost_r;
    days_ext      = 32'(days_r);
    if (do_take) begin
      price_nxt = q_item.price;
      days_nxt  = SPAN_BITS'(1);
      if (q_item.start_of_series) begin
        cnt_nxt  = '0;
        lost_nxt = 1'b0;
      end
    end else if (state_r == ssk_pkg::ST_SCAN) begin
      if (pop_hit) begin
        days_nxt = span_sat;
        cnt_nxt  = cnt_r - 1'b1;
      end else if (do_push) begin
        if (cnt_r == DEPTH_C) begin
          base_nxt = (base_r == PTR_LAST) ? '0 : base_r + 1'b1;
          lost_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
        out_valid_nxt = 1'b1;
        out_span_nxt  = days_ext[ssk_pkg::OUT_SPAN_W-1:0];
        out_lost_nxt  = (cnt_r == DEPTH_C) || lost_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssk_pkg::ST_IDLE;
      base_r      <= '0;
      cnt_r       <= '0;
      lost_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r    <= price_nxt;
    days_r     <= days_nxt;
    out_span_r <= out_span_nxt;
    out_lost_r <= out_lost_nxt;
  end

  // stack memory, registered read of the next top entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_idx] <= {price_r, days_r};
    end
    rd_data_r <= mem[rd_idx];
  end

  assign out_empty        = !out_valid_r;
  assign out_span_days    = out_span_r;
  assign out_history_lost = out_lost_r;

endmodule
`default_nettype wire

FILE: tb/stock_span_stack_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stock_span_stack_top_tb
// self-checking bench for the streaming stock span unit
// ----------------------------------------------------------------------------
// a queue of pending prices feeds a bursty driver; every accepted item runs
// through a span predictor with its own monotonic stack, and the monitor
// compares each popped result against the oldest predicted span. covers
// price extremes, equal prices, series restarts, a stack overflow that
// drops the bottom entry, and a long non-decreasing run.
// the receiver stalls on shifting patterns and holds off once for a long stretch
// so the input side backs up.
// ----------------------------------------------------------------------------
module stock_span_stack_top_tb;

  localparam int STACK_DEPTH = ssk_pkg::DEF_STACK_DEPTH;
  localparam int SPAN_BITS   = ssk_pkg::DEF_SPAN_BITS;
  localparam int unsigned SPAN_MAX = (1 << SPAN_BITS) - 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [ssk_pkg::OUT_SPAN_W-1:0] span_days;
    logic                           history_lost;
  } span_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [ssk_pkg::PRICE_W-1:0] in_price = '0;
  logic in_start_of_series = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [ssk_pkg::OUT_SPAN_W-1:0] out_span_days;
  logic out_history_lost;

  ssk_pkg::item_t price_q[$];
  span_result_t   due_spans[$];

  logic signed [ssk_pkg::PRICE_W-1:0] stk_price[STACK_DEPTH];
  logic [SPAN_BITS-1:0]               stk_days[STACK_DEPTH];
  int                                 stk_n = 0;
  logic                               stk_lost = 1'b0;

  int mismatches = 0;
  int results_seen = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int mode_left = 0;
  int pop_mode = 0;
  int pop_phase = 0;
  span_result_t got_due;

  stock_span_stack_top #(
    .STACK_DEPTH(STACK_DEPTH),
    .SPAN_BITS  (SPAN_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_price          (in_price),
    .in_start_of_series(in_start_of_series),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_span_days     (out_span_days),
    .out_history_lost  (out_history_lost)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic span_of_price(input logic signed [ssk_pkg::PRICE_W-1:0] price,
                               input logic restart);
    int unsigned days;
    span_result_t res;
    days = 1;
    if (restart) begin
      stk_n = 0;
      stk_lost = 1'b0;
    end
    while (stk_n > 0 && stk_price[stk_n-1] <= price) begin
      days += stk_days[stk_n-1];
      if (days > SPAN_MAX) days = SPAN_MAX;
      stk_n--;
    end
    if (stk_n >= STACK_DEPTH) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stk_price[i] = stk_price[i+1];
        stk_days[i]  = stk_days[i+1];
      end
      stk_n = STACK_DEPTH - 1;
      stk_lost = 1'b1;
    end
    stk_price[stk_n] = price;
    stk_days[stk_n]  = days[SPAN_BITS-1:0];
    stk_n++;
    res.span_days    = days[ssk_pkg::OUT_SPAN_W-1:0];
    res.history_lost = stk_lost;
    due_spans = {due_spans, res};
  endtask

  task automatic add_item(input logic signed [ssk_pkg::PRICE_W-1:0] price,
                          input logic restart);
    ssk_pkg::item_t it;
    it.price = price;
    it.start_of_series = restart;
    price_q = {price_q, it};
  endtask

  task automatic wait_drain();
    while (price_q.size() != 0 || due_spans.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input bit none_due, input span_result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      if (none_due)
        $display("mismatch: result with no item due, span %0d lost %0b",
                 out_span_days, out_history_lost);
      else
        $display("mismatch: span exp %0d got %0d, lost exp %0b got %0b",
                 want.span_days, out_span_days, want.history_lost, out_history_lost);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_price <= '0;
      in_start_of_series <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_push && !in_full) begin
        span_of_price(in_price, in_start_of_series);
        void'(price_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (price_q.size() > 0) begin
        in_push <= 1'b1;
        in_price <= price_q[0].price;
        in_start_of_series <= price_q[0].start_of_series;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (due_spans.size() == 0) begin
          report_mismatch(1'b1, '0);
        end else begin
          got_due = due_spans.pop_front();
          if (out_span_days !== got_due.span_days || out_history_lost !== got_due.history_lost)
            report_mismatch(1'b0, got_due);
        end
        if (results_seen % 20000 == 30) hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      pop_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case (pop_mode)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: out_pop <= (pop_phase % 4 == 0);
          default: out_pop <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int n;
    int len;
    int kind;
    int p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed extremes
    add_item(32'sd0, 1'b1);
    add_item(32'sh7FFFFFFF, 1'b0);
    add_item(32'sh80000000, 1'b0);
    add_item(32'sh80000000, 1'b0);
    add_item(-32'sd1, 1'b0);
    add_item(32'sh7FFFFFFF, 1'b0);
    add_item(32'sh7FFFFFFF, 1'b0);
    add_item(32'sd5, 1'b1);
    add_item(32'sd3, 1'b0);
    add_item(32'sd4, 1'b0);
    add_item(32'sd4, 1'b0);
    add_item(32'sd10, 1'b0);
    add_item(32'sh80000000, 1'b1);
    add_item(32'shAAAAAAAA, 1'b0);
    add_item(32'sh55555555, 1'b0);
    add_item(32'sd100, 1'b0);
    add_item(32'sd99, 1'b0);
    add_item(32'sd101, 1'b0);
    wait_drain();

    // overflow the stack, then sweep it and restart the series
    add_item(32'sh7FFFFFFF, 1'b1);
    for (int i = 0; i < 70; i++) add_item(2000000 - i * 7, 1'b0);
    add_item(32'sh7FFFFFFF, 1'b0);
    add_item(32'sd0, 1'b1);
    add_item(-32'sd5, 1'b0);
    wait_drain();

    // long non-decreasing run
    p = -1000000;
    add_item(p, 1'b1);
    for (int i = 0; i < 100; i++) begin
      p += $urandom_range(0, 2);
      add_item(p, 1'b0);
    end
    add_item(p - 1, 1'b0);
    add_item(p + 1, 1'b0);
    wait_drain();

    // random runs
    n = 0;
    while (n < 500) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          add_item($urandom, 1'b1);
          n++;
        end
        1: begin
          len = $urandom_range(60, 75);
          p = 2000000000 - $urandom_range(0, 1000);
          for (int i = 0; i < len; i++) begin
            add_item(p, 1'b0);
            p -= $urandom_range(1, 1000);
          end
          n += len;
        end
        2, 3: begin
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++) add_item($urandom, $urandom_range(0, 15) == 0);
          n += len;
        end
        default: begin
          len = $urandom_range(1, 30);
          for (int i = 0; i < len; i++)
            add_item(int'($urandom_range(0, 16)) - 8, $urandom_range(0, 19) == 0);
          n += len;
        end
      endcase
    end
    wait_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_spans.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
